[rtl/core/mraa_pkg.sv]
// Shared types, sizes and codes for the multi-resource allocator.
// Used by every module of the allocator; depends on nothing.
package mraa_pkg;

  localparam int NUM_TYPES  = 16;
  localparam int NUM_JOBS   = 32;
  localparam int COUNT_BITS = 8;

  // Fixed widths of the transaction fields
  localparam int OP_W     = 2;
  localparam int JOB_IN_W = 5;
  localparam int TYP_IN_W = 4;
  localparam int AMT_IN_W = 8;
  localparam int BLOCK_W  = 4;
  localparam int AVAIL_W  = 8;

  localparam int TYPE_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int JOB_W      = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
  localparam int NEED_DEPTH = NUM_JOBS * NUM_TYPES;
  localparam int NEED_AW    = (NEED_DEPTH > 1) ? $clog2(NEED_DEPTH) : 1;
  localparam int SCAN_W     = $clog2(NUM_TYPES + 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [TYPE_W-1:0]     type_idx_t;
  typedef logic [JOB_W-1:0]      job_idx_t;
  typedef logic [NEED_AW-1:0]    need_addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_SET_CAP  = 2'd0,
    OP_SET_NEED = 2'd1,
    OP_ACQUIRE  = 2'd2,
    OP_RELEASE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_NO_HOLD = 2'd2,
    ST_HOLDING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_COMMIT,
    S_RELEASE,
    S_READ,
    S_RESULT
  } seq_state_e;

  // Access requests from the sequencer to the two memories
  typedef struct packed {
    logic       av_we;
    type_idx_t  av_waddr;
    cnt_t       av_wdata;
    logic       av_re;
    type_idx_t  av_raddr;
    logic       nd_we;
    need_addr_t nd_waddr;
    cnt_t       nd_wdata;
    logic       nd_re;
    need_addr_t nd_raddr;
  } mem_req_t;

  typedef struct packed {
    status_e              status;
    logic [BLOCK_W-1:0]   block;
    logic [AVAIL_W-1:0]   avail;
  } res_t;

endpackage

[rtl/core/mraa_store.sv]
// Available-count memory and need-table memory of the allocator.
// One write and one registered read port each; depends on mraa_pkg.
module mraa_store (
  input  logic              clk_i,
  input  mraa_pkg::mem_req_t mem_i,
  output mraa_pkg::cnt_t    av_rdata_o,
  output mraa_pkg::cnt_t    nd_rdata_o
);

  mraa_pkg::cnt_t av_mem [mraa_pkg::NUM_TYPES];
  mraa_pkg::cnt_t nd_mem [mraa_pkg::NEED_DEPTH];
  mraa_pkg::cnt_t av_rdata_q;
  mraa_pkg::cnt_t nd_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.av_we) begin
      av_mem[mem_i.av_waddr] <= mem_i.av_wdata;
    end
    if (mem_i.av_re) begin
      av_rdata_q <= av_mem[mem_i.av_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_i.nd_we) begin
      nd_mem[mem_i.nd_waddr] <= mem_i.nd_wdata;
    end
    if (mem_i.nd_re) begin
      nd_rdata_q <= nd_mem[mem_i.nd_raddr];
    end
  end

  assign av_rdata_o = av_rdata_q;
  assign nd_rdata_o = nd_rdata_q;

endmodule

[rtl/core/mraa_seq.sv]
// Sequencer of the allocator: decodes a transaction, scans the type entries
// through the memories and builds the result. Depends on mraa_pkg.
module mraa_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [mraa_pkg::OP_W-1:0]      op_i,
  input  logic [mraa_pkg::JOB_IN_W-1:0]  job_id_i,
  input  logic [mraa_pkg::TYP_IN_W-1:0]  res_type_i,
  input  logic [mraa_pkg::AMT_IN_W-1:0]  amount_i,
  output logic                           ready_o,
  input  logic                           out_free_i,
  output logic                           res_valid_o,
  output mraa_pkg::res_t                 res_o,
  output mraa_pkg::mem_req_t             mem_o,
  input  mraa_pkg::cnt_t                 av_rdata_i,
  input  mraa_pkg::cnt_t                 nd_rdata_i
);

  mraa_pkg::seq_state_e state_q, state_d;

  mraa_pkg::op_e                  op_q, op_d;
  logic [mraa_pkg::JOB_IN_W-1:0]  job_q, job_d;
  logic [mraa_pkg::TYP_IN_W-1:0]  typ_q, typ_d;
  mraa_pkg::cnt_t                 amt_q, amt_d;
  logic [mraa_pkg::SCAN_W-1:0]    iss_q, iss_d;
  logic                           rv_q, rv_d;
  mraa_pkg::type_idx_t            rt_q, rt_d;
  logic                           short_q, short_d;
  mraa_pkg::status_e              status_q, status_d;
  mraa_pkg::type_idx_t            block_q, block_d;
  mraa_pkg::need_addr_t           clr_q, clr_d;
  logic [mraa_pkg::NUM_JOBS-1:0]  hold_q, hold_d;

  logic                 type_ok, job_ok, hold_cur;
  mraa_pkg::type_idx_t  tidx, iss_idx;
  mraa_pkg::job_idx_t   jidx;
  mraa_pkg::need_addr_t base;
  logic                 issuing, last, short_now, found, clr_last, clr_av;
  logic [mraa_pkg::COUNT_BITS:0] sum;

  assign type_ok  = int'(typ_q) < mraa_pkg::NUM_TYPES;
  assign job_ok   = int'(job_q) < mraa_pkg::NUM_JOBS;
  assign tidx     = mraa_pkg::TYPE_W'(typ_q);
  assign jidx     = mraa_pkg::JOB_W'(job_q);
  assign hold_cur = hold_q[jidx];
  assign base     = mraa_pkg::NEED_AW'(jidx) * mraa_pkg::NEED_AW'(mraa_pkg::NUM_TYPES);

  assign iss_idx   = iss_q[mraa_pkg::TYPE_W-1:0];
  assign issuing   = iss_q < mraa_pkg::SCAN_W'(mraa_pkg::NUM_TYPES);
  assign last      = rv_q && (rt_q == mraa_pkg::TYPE_W'(mraa_pkg::NUM_TYPES - 1));
  assign short_now = rv_q && (nd_rdata_i > av_rdata_i);
  assign found     = short_q || short_now;
  assign clr_last  = clr_q == mraa_pkg::NEED_AW'(mraa_pkg::NEED_DEPTH - 1);
  assign clr_av    = {1'b0, clr_q} < (mraa_pkg::NEED_AW + 1)'(mraa_pkg::NUM_TYPES);
  assign sum       = {1'b0, av_rdata_i} + {1'b0, nd_rdata_i};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mraa_pkg::S_CLEAR: begin
        if (clr_last) state_d = mraa_pkg::S_IDLE;
      end
      mraa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mraa_pkg::S_EXEC;
      end
      mraa_pkg::S_EXEC: begin
        state_d = mraa_pkg::S_READ;
        if (op_q == mraa_pkg::OP_ACQUIRE && job_ok && !hold_cur) begin
          state_d = mraa_pkg::S_CHECK;
        end
        if (op_q == mraa_pkg::OP_RELEASE && job_ok && hold_cur) begin
          state_d = mraa_pkg::S_RELEASE;
        end
      end
      mraa_pkg::S_CHECK: begin
        if (last) state_d = found ? mraa_pkg::S_READ : mraa_pkg::S_COMMIT;
      end
      mraa_pkg::S_COMMIT,
      mraa_pkg::S_RELEASE: begin
        if (last) state_d = mraa_pkg::S_READ;
      end
      mraa_pkg::S_READ: begin
        state_d = mraa_pkg::S_RESULT;
      end
      mraa_pkg::S_RESULT: begin
        if (out_free_i) state_d = mraa_pkg::S_IDLE;
      end
      default: state_d = mraa_pkg::S_CLEAR;
    endcase
  end

  // Memory requests and handshake outputs
  always_comb begin
    mem_o       = '0;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      mraa_pkg::S_CLEAR: begin
        mem_o.nd_we    = 1'b1;
        mem_o.nd_waddr = clr_q;
        mem_o.av_we    = clr_av;
        mem_o.av_waddr = clr_q[mraa_pkg::TYPE_W-1:0];
      end
      mraa_pkg::S_IDLE: begin
        ready_o = 1'b1;
      end
      mraa_pkg::S_EXEC: begin
        if (op_q == mraa_pkg::OP_SET_CAP && type_ok) begin
          mem_o.av_we    = 1'b1;
          mem_o.av_waddr = tidx;
          mem_o.av_wdata = amt_q;
        end
        if (op_q == mraa_pkg::OP_SET_NEED && type_ok && job_ok) begin
          mem_o.nd_we    = 1'b1;
          mem_o.nd_waddr = base + mraa_pkg::NEED_AW'(tidx);
          mem_o.nd_wdata = amt_q;
        end
      end
      mraa_pkg::S_CHECK,
      mraa_pkg::S_COMMIT,
      mraa_pkg::S_RELEASE: begin
        mem_o.av_re    = issuing;
        mem_o.av_raddr = iss_idx;
        mem_o.nd_re    = issuing;
        mem_o.nd_raddr = base + mraa_pkg::NEED_AW'(iss_idx);
        // write back the entry read in the previous cycle
        if (state_q == mraa_pkg::S_COMMIT) begin
          mem_o.av_we    = rv_q;
          mem_o.av_waddr = rt_q;
          mem_o.av_wdata = av_rdata_i - nd_rdata_i;
        end
        if (state_q == mraa_pkg::S_RELEASE) begin
          mem_o.av_we    = rv_q;
          mem_o.av_waddr = rt_q;
          mem_o.av_wdata = sum[mraa_pkg::COUNT_BITS] ? '1 : sum[mraa_pkg::COUNT_BITS-1:0];
        end
      end
      mraa_pkg::S_READ: begin
        mem_o.av_re    = 1'b1;
        mem_o.av_raddr = tidx;
      end
      mraa_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: begin
        mem_o = '0;
      end
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.block  = mraa_pkg::BLOCK_W'(block_q);
  assign res_o.avail  = type_ok ? mraa_pkg::AVAIL_W'(av_rdata_i) : '0;

  // Datapath registers
  always_comb begin
    op_d     = op_q;
    job_d    = job_q;
    typ_d    = typ_q;
    amt_d    = amt_q;
    iss_d    = iss_q;
    rv_d     = 1'b0;
    rt_d     = rt_q;
    short_d  = short_q;
    status_d = status_q;
    block_d  = block_q;
    clr_d    = clr_q;
    hold_d   = hold_q;
    case (state_q)
      mraa_pkg::S_CLEAR: begin
        clr_d = clr_q + 1'b1;
      end
      mraa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d     = mraa_pkg::op_e'(op_i);
          job_d    = job_id_i;
          typ_d    = res_type_i;
          amt_d    = mraa_pkg::COUNT_BITS'(amount_i);
          status_d = mraa_pkg::ST_OK;
          block_d  = '0;
        end
      end
      mraa_pkg::S_EXEC: begin
        iss_d   = '0;
        short_d = 1'b0;
        if (op_q == mraa_pkg::OP_ACQUIRE && job_ok && hold_cur) begin
          status_d = mraa_pkg::ST_HOLDING;
        end
        if (op_q == mraa_pkg::OP_RELEASE && job_ok && !hold_cur) begin
          status_d = mraa_pkg::ST_NO_HOLD;
        end
      end
      mraa_pkg::S_CHECK,
      mraa_pkg::S_COMMIT,
      mraa_pkg::S_RELEASE: begin
        rv_d = issuing;
        rt_d = iss_idx;
        if (issuing) iss_d = iss_q + 1'b1;
        if (state_q == mraa_pkg::S_CHECK) begin
          // keep the first type that falls short
          if (short_now && !short_q) begin
            short_d = 1'b1;
            block_d = rt_q;
          end
          if (last) begin
            iss_d = '0;
            if (found) status_d = mraa_pkg::ST_DENIED;
          end
        end
        if (state_q == mraa_pkg::S_COMMIT && last) hold_d[jidx] = 1'b1;
        if (state_q == mraa_pkg::S_RELEASE && last) hold_d[jidx] = 1'b0;
      end
      default: begin
        rv_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mraa_pkg::S_CLEAR;
      clr_q   <= '0;
      hold_q  <= '0;
      iss_q   <= '0;
      rv_q    <= 1'b0;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hold_q  <= hold_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
      short_q <= short_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    job_q    <= job_d;
    typ_q    <= typ_d;
    amt_q    <= amt_d;
    rt_q     <= rt_d;
    status_q <= status_d;
    block_q  <= block_d;
  end

endmodule

[rtl/core/multi_resource_all_or_nothing_allocator_top.sv]
// Top level of the multi-resource all-or-nothing allocator.
// Instantiates mraa_seq and mraa_store and holds the result register; uses mraa_pkg.

// After reset the block runs a clearing pass over the NUM_JOBS*NUM_TYPES
// entries (512 by default) of the need table and the available counts, with
// in_stall_o high, and then takes one transaction at a time. Every type
// entry goes through the single read port of each memory, one type per
// cycle: a set capacity or set need transaction or a rejected request needs
// no scan, a release or a denied acquire scans the types once, and a granted
// acquire scans them twice, once to check every type and once more to
// subtract. A finished result waits in the output register while the next
// transaction is accepted; the following result waits for that register.
module multi_resource_all_or_nothing_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mraa_pkg::OP_W-1:0]      op_i,
  input  logic [mraa_pkg::JOB_IN_W-1:0]  job_id_i,
  input  logic [mraa_pkg::TYP_IN_W-1:0]  res_type_i,
  input  logic [mraa_pkg::AMT_IN_W-1:0]  amount_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [mraa_pkg::BLOCK_W-1:0]   blocking_type_o,
  output logic [mraa_pkg::AVAIL_W-1:0]   available_now_o
);

  mraa_pkg::mem_req_t mem_req;
  mraa_pkg::cnt_t     av_rdata, nd_rdata;
  mraa_pkg::res_t     res;
  logic               seq_ready, res_valid, out_free;

  logic               out_valid_q, out_valid_d;
  mraa_pkg::res_t     out_q;

  assign in_stall_o = !seq_ready;
  assign out_free   = !out_valid_q || !out_stall_i;

  mraa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .job_id_i    (job_id_i),
    .res_type_i  (res_type_i),
    .amount_i    (amount_i),
    .ready_o     (seq_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem_req),
    .av_rdata_i  (av_rdata),
    .nd_rdata_i  (nd_rdata)
  );

  mraa_store u_store (
    .clk_i      (clk_i),
    .mem_i      (mem_req),
    .av_rdata_o (av_rdata),
    .nd_rdata_o (nd_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load a new result only when the register is empty or being taken
  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign blocking_type_o = out_q.block;
  assign available_now_o = out_q.avail;

endmodule

[rtl/core/mraa_chk.sv]
// Port-level assertions for the allocator top level, and the bind that
// attaches them. Depends on mraa_pkg for the status codes.
module mraa_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic [mraa_pkg::BLOCK_W-1:0]  blocking_type_o,
  input logic [mraa_pkg::AVAIL_W-1:0]  available_now_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(blocking_type_o)
      && $stable(available_now_o))
    else $error("result changed while stalled");

  // One transaction at a time: the input stalls right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted in back-to-back cycles");

  // A blocking type is reported only with a denial.
  a_block_denied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blocking_type_o != '0 |-> status_o == mraa_pkg::ST_DENIED)
    else $error("blocking type without denial");

  // The input stays stalled while reset is held.
  a_reset_stall: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o && !out_valid_o)
    else $error("ready or result during reset");

endmodule

bind multi_resource_all_or_nothing_allocator_top mraa_chk u_mraa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .blocking_type_o (blocking_type_o),
  .available_now_o (available_now_o)
);

[tb/multi_resource_all_or_nothing_allocator_top_test.sv]
// Self-checking testbench for multi_resource_all_or_nothing_allocator_top.
// Drives a directed table and then random transactions, and predicts every result in place.
// Depends on mraa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module multi_resource_all_or_nothing_allocator_top_test;

  localparam int HALF_PERIOD    = 5;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT    = 3000;  // clearing pass, holdoff and slow acquires fit well inside
  localparam int DRAIN_CYCLES   = 60;
  localparam int ITEMS_PER_PHASE = 420;
  localparam int N_DIRECTED     = 25;
  localparam int EXP_DEPTH      = 8;
  localparam int CNT_MAX        = (1 << mraa_pkg::COUNT_BITS) - 1;

  typedef struct packed {
    mraa_pkg::op_e                   op;
    logic [mraa_pkg::JOB_IN_W-1:0]   job;
    logic [mraa_pkg::TYP_IN_W-1:0]   typ;
    logic [mraa_pkg::AMT_IN_W-1:0]   amt;
    logic                            typed;
    mraa_pkg::status_e               want_status;
    logic [mraa_pkg::BLOCK_W-1:0]    want_block;
    logic [mraa_pkg::AVAIL_W-1:0]    want_avail;
  } row_t;

  // Rows with typed set carry an expectation read straight off the spec.
  row_t directed_rows [N_DIRECTED] = '{
    '{mraa_pkg::OP_ACQUIRE,  5'd0,  4'd0,  8'd0,   1'b1, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_RELEASE,  5'd0,  4'd0,  8'd0,   1'b1, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_RELEASE,  5'd0,  4'd0,  8'd0,   1'b1, mraa_pkg::ST_NO_HOLD, 4'd0, 8'd0},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd15, 8'd255, 1'b1, mraa_pkg::ST_OK,      4'd0, 8'd255},
    '{mraa_pkg::OP_SET_NEED, 5'd31, 4'd15, 8'd255, 1'b1, mraa_pkg::ST_OK,      4'd0, 8'd255},
    '{mraa_pkg::OP_SET_NEED, 5'd31, 4'd3,  8'd1,   1'b1, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd31, 4'd15, 8'd0,   1'b1, mraa_pkg::ST_DENIED,  4'd3, 8'd255},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd3,  8'd200, 1'b1, mraa_pkg::ST_OK,      4'd0, 8'd200},
    '{mraa_pkg::OP_ACQUIRE,  5'd31, 4'd15, 8'd0,   1'b1, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd31, 4'd3,  8'd0,   1'b1, mraa_pkg::ST_HOLDING, 4'd0, 8'd199},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd15, 8'd10,  1'b1, mraa_pkg::ST_OK,      4'd0, 8'd10},
    '{mraa_pkg::OP_SET_NEED, 5'd31, 4'd3,  8'd170, 1'b1, mraa_pkg::ST_OK,      4'd0, 8'd199},
    '{mraa_pkg::OP_RELEASE,  5'd31, 4'd15, 8'd0,   1'b1, mraa_pkg::ST_OK,      4'd0, 8'd255},
    '{mraa_pkg::OP_RELEASE,  5'd31, 4'd3,  8'd0,   1'b1, mraa_pkg::ST_NO_HOLD, 4'd0, 8'd255},
    '{mraa_pkg::OP_SET_NEED, 5'd10, 4'd0,  8'd1,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_SET_NEED, 5'd10, 4'd10, 8'hAA,  1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd10, 4'd10, 8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd0,  8'h55,  1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd10, 4'd0,  8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd10, 8'hAA,  1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd10, 4'd10, 8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_SET_NEED, 5'd21, 4'd5,  8'h55,  1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_ACQUIRE,  5'd21, 4'd5,  8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_RELEASE,  5'd10, 4'd0,  8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0},
    '{mraa_pkg::OP_SET_CAP,  5'd0,  4'd0,  8'd0,   1'b0, mraa_pkg::ST_OK,      4'd0, 8'd0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [mraa_pkg::OP_W-1:0]       op_i = '0;
  logic [mraa_pkg::JOB_IN_W-1:0]   job_id_i = '0;
  logic [mraa_pkg::TYP_IN_W-1:0]   res_type_i = '0;
  logic [mraa_pkg::AMT_IN_W-1:0]   amount_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      status_o;
  logic [mraa_pkg::BLOCK_W-1:0]    blocking_type_o;
  logic [mraa_pkg::AVAIL_W-1:0]    available_now_o;

  // Typed expectation travels with the payload so the monitor sees it at the accept edge.
  logic                            row_typed = 1'b0;
  mraa_pkg::res_t                  row_want = '0;

  // Allocator state as predicted
  bit [mraa_pkg::COUNT_BITS-1:0]   avail_units [mraa_pkg::NUM_TYPES];
  bit [mraa_pkg::COUNT_BITS-1:0]   job_needs [mraa_pkg::NUM_JOBS][mraa_pkg::NUM_TYPES];
  bit                              job_holds [mraa_pkg::NUM_JOBS];

  // Ring of expected results, written and read by free-running counts
  mraa_pkg::res_t                  expected_results [EXP_DEPTH];
  int                              exp_wr = 0;
  int                              exp_rd = 0;
  int                              mismatches = 0;
  int                              accepted_requests = 0;
  int                              status_seen [4] = '{0, 0, 0, 0};
  int                              send_idle_pct = 0;
  int                              recv_stall_pct = 0;
  int                              holdoff_req = 0;
  int                              holdoff_ack = 0;
  int                              holdoff_left = 0;
  int                              quiet_cycles = 0;

  multi_resource_all_or_nothing_allocator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .job_id_i        (job_id_i),
    .res_type_i      (res_type_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .blocking_type_o (blocking_type_o),
    .available_now_o (available_now_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Advance the predicted state by one request and return its result.
  function automatic mraa_pkg::res_t allocate_step(mraa_pkg::op_e op,
                                                   logic [mraa_pkg::JOB_IN_W-1:0] job,
                                                   logic [mraa_pkg::TYP_IN_W-1:0] typ,
                                                   logic [mraa_pkg::AMT_IN_W-1:0] amt);
    mraa_pkg::res_t r;
    bit             short_found;
    int             sum;
    r = '0;
    r.status = mraa_pkg::ST_OK;
    case (op)
      mraa_pkg::OP_SET_CAP: avail_units[typ] = amt;
      mraa_pkg::OP_SET_NEED: job_needs[job][typ] = amt;
      mraa_pkg::OP_ACQUIRE: begin
        if (job_holds[job]) begin
          r.status = mraa_pkg::ST_HOLDING;
        end else begin
          short_found = 1'b0;
          for (int t = 0; t < mraa_pkg::NUM_TYPES; t++) begin
            if (!short_found && job_needs[job][t] > avail_units[t]) begin
              short_found = 1'b1;
              r.block = mraa_pkg::BLOCK_W'(t);
            end
          end
          if (short_found) begin
            r.status = mraa_pkg::ST_DENIED;
          end else begin
            for (int t = 0; t < mraa_pkg::NUM_TYPES; t++) avail_units[t] -= job_needs[job][t];
            job_holds[job] = 1'b1;
          end
        end
      end
      default: begin
        if (!job_holds[job]) begin
          r.status = mraa_pkg::ST_NO_HOLD;
        end else begin
          for (int t = 0; t < mraa_pkg::NUM_TYPES; t++) begin
            sum = int'(avail_units[t]) + int'(job_needs[job][t]);
            avail_units[t] = (sum > CNT_MAX) ? CNT_MAX[mraa_pkg::COUNT_BITS-1:0]
                                             : sum[mraa_pkg::COUNT_BITS-1:0];
          end
          job_holds[job] = 1'b0;
        end
      end
    endcase
    r.avail = avail_units[typ];
    return r;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic offer(input row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= row.op;
    job_id_i <= row.job;
    res_type_i <= row.typ;
    amount_i <= row.amt;
    row_typed <= row.typed;
    row_want <= '{status: row.want_status, block: row.want_block, avail: row.want_avail};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random transaction biased toward a few busy jobs so acquires and releases pair up.
  function automatic row_t random_row();
    row_t row;
    int   pick;
    row = '0;
    pick = $urandom_range(0, 99);
    row.job = ($urandom_range(0, 99) < 80)
              ? mraa_pkg::JOB_IN_W'($urandom_range(0, 5))
              : mraa_pkg::JOB_IN_W'($urandom_range(0, mraa_pkg::NUM_JOBS - 1));
    row.typ = mraa_pkg::TYP_IN_W'($urandom_range(0, 15));
    row.amt = mraa_pkg::AMT_IN_W'($urandom_range(0, 255));
    if (pick < 12) begin
      row.op = mraa_pkg::OP_SET_CAP;
      if ($urandom_range(0, 99) < 70) row.amt = mraa_pkg::AMT_IN_W'($urandom_range(30, 255));
    end else if (pick < 35) begin
      row.op = mraa_pkg::OP_SET_NEED;
      pick = $urandom_range(0, 99);
      if (pick < 60) row.amt = mraa_pkg::AMT_IN_W'($urandom_range(0, 12));
      else if (pick < 85) row.amt = '0;
    end else if (pick < 70) begin
      row.op = mraa_pkg::OP_ACQUIRE;
    end else begin
      row.op = mraa_pkg::OP_RELEASE;
    end
    return row;
  endfunction

  // Receiver: random stall, plus a long holdoff when requested.
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (holdoff_req != holdoff_ack) begin
      holdoff_ack = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check results first, then predict the transaction taken at this edge.
  always @(posedge clk_i) begin
    mraa_pkg::res_t want;
    mraa_pkg::res_t predicted;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        status_seen[status_o]++;
        if (exp_wr == exp_rd) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual status %0d block %0d avail %0d",
                   $time, status_o, blocking_type_o, available_now_o);
        end else begin
          want = expected_results[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status_o);
          end
          if (blocking_type_o !== want.block) begin
            mismatches++;
            $display("%0t: blocking_type mismatch, expected %0d actual %0d",
                     $time, want.block, blocking_type_o);
          end
          if (available_now_o !== want.avail) begin
            mismatches++;
            $display("%0t: available_now mismatch, expected %0d actual %0d",
                     $time, want.avail, available_now_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accepted_requests++;
        predicted = allocate_step(mraa_pkg::op_e'(op_i), job_id_i, res_type_i, amount_i);
        expected_results[exp_wr % EXP_DEPTH] = row_typed ? row_want : predicted;
        exp_wr++;
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, exp_wr - exp_rd);
      $display("multi_resource_all_or_nothing_allocator_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) offer(directed_rows[i]);

    // Fill the block while the receiver holds off.
    holdoff_req <= holdoff_req + 1;
    for (int i = 0; i < 20; i++) offer(random_row());

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) offer(random_row());
    end
    in_valid_i <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests under four idle/stall mixes plus a long output holdoff.",
             accepted_requests);
    $display("Results: %0d ok, %0d denied, %0d release without hold, %0d acquire while holding.",
             status_seen[mraa_pkg::ST_OK], status_seen[mraa_pkg::ST_DENIED],
             status_seen[mraa_pkg::ST_NO_HOLD], status_seen[mraa_pkg::ST_HOLDING]);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("multi_resource_all_or_nothing_allocator_top_test OK");
    end else begin
      $display("multi_resource_all_or_nothing_allocator_top_test NOT OK");
    end
    $finish;
  end

endmodule
